### design/pcts_pkg.sv
// shared types and constants for the packed column threshold scan
`default_nettype none

package pcts_pkg;

  localparam int CODE_BITS  = 17;
  localparam int WORD_BITS  = 64;
  localparam int CARRY_BITS = CODE_BITS - 1;
  localparam int EXT_BITS   = WORD_BITS + CARRY_BITS;
  localparam int MAX_CODES  = EXT_BITS / CODE_BITS;
  localparam int LEN_W      = $clog2(CODE_BITS);
  localparam int TOT_W      = $clog2(EXT_BITS + 1);
  localparam int HIT_W      = $clog2(MAX_CODES + 1);
  localparam int CNT_W      = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_COUNT = 2'd1;

  typedef logic [CODE_BITS-1:0] code_t;

  // codes finished by one word, earliest first
  typedef struct packed {
    logic [MAX_CODES-1:0]             complete;
    logic [MAX_CODES-1:0][CODE_BITS-1:0] code;
  } code_bundle_t;

endpackage

`default_nettype wire

### design/pcts_unpack.sv
// splits a packed word plus leftover bits into codes and keeps the leftover
`default_nettype none

module pcts_unpack (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  step,
  input  wire  [pcts_pkg::WORD_BITS-1:0]       word,
  input  wire                                  first_word,
  output pcts_pkg::code_bundle_t               codes
);

  logic [pcts_pkg::CARRY_BITS-1:0] carry_bits_r;
  logic [pcts_pkg::CARRY_BITS-1:0] carry_bits_nxt;
  logic [pcts_pkg::LEN_W-1:0]      carry_len_r;
  logic [pcts_pkg::LEN_W-1:0]      carry_len_nxt;

  logic [pcts_pkg::CARRY_BITS-1:0] bits_eff;
  logic [pcts_pkg::LEN_W-1:0]      len_eff;
  logic [pcts_pkg::EXT_BITS-1:0]   ext;
  logic [pcts_pkg::EXT_BITS-1:0]   aligned;
  logic [pcts_pkg::LEN_W-1:0]      shamt;
  logic [pcts_pkg::TOT_W-1:0]      avail;
  logic [pcts_pkg::TOT_W-1:0]      rem;
  logic [pcts_pkg::CARRY_BITS-1:0] keep_mask;

  always_comb begin
    bits_eff = first_word ? '0 : carry_bits_r;
    len_eff  = first_word ? '0 : carry_len_r;
    ext      = {bits_eff, word};
    // left-justify the live bits so code slots sit at fixed positions
    shamt    = pcts_pkg::LEN_W'(pcts_pkg::CARRY_BITS) - len_eff;
    aligned  = ext << shamt;
    avail    = pcts_pkg::TOT_W'(len_eff) + pcts_pkg::TOT_W'(pcts_pkg::WORD_BITS);
    rem      = avail;
    for (int j = 0; j < pcts_pkg::MAX_CODES; j++) begin
      codes.code[j]     = aligned[pcts_pkg::EXT_BITS-1-j*pcts_pkg::CODE_BITS -:
                                  pcts_pkg::CODE_BITS];
      codes.complete[j] = avail >= pcts_pkg::TOT_W'((j + 1) * pcts_pkg::CODE_BITS);
      if (codes.complete[j]) begin
        rem = rem - pcts_pkg::TOT_W'(pcts_pkg::CODE_BITS);
      end
    end
    carry_len_nxt  = rem[pcts_pkg::LEN_W-1:0];
    keep_mask      = ~({pcts_pkg::CARRY_BITS{1'b1}} << carry_len_nxt);
    carry_bits_nxt = ext[pcts_pkg::CARRY_BITS-1:0] & keep_mask;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_bits_r <= '0;
      carry_len_r  <= '0;
    end else if (step) begin
      carry_bits_r <= carry_bits_nxt;
      carry_len_r  <= carry_len_nxt;
    end
  end

endmodule

`default_nettype wire

### design/pcts_count.sv
// threshold compare and running counters for the codes of one word
`default_nettype none

module pcts_count (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                step,
  input  wire                                first_word,
  input  wire  pcts_pkg::code_bundle_t       codes,
  input  wire  [pcts_pkg::CODE_BITS-1:0]     threshold,
  input  wire  [pcts_pkg::CNT_W-1:0]         value_count,
  output logic [pcts_pkg::HIT_W-1:0]         word_matches,
  output logic [pcts_pkg::CNT_W-1:0]         total_matches,
  output logic                               done_res
);

  logic [pcts_pkg::CNT_W-1:0] seen_r;
  logic [pcts_pkg::CNT_W-1:0] seen_nxt;
  logic [pcts_pkg::CNT_W-1:0] total_r;
  logic [pcts_pkg::CNT_W-1:0] total_nxt;

  logic [pcts_pkg::CNT_W-1:0] seen_eff;
  logic [pcts_pkg::CNT_W-1:0] total_eff;
  logic [pcts_pkg::CNT_W:0]   slot;
  logic [pcts_pkg::HIT_W-1:0] hits;
  logic [pcts_pkg::HIT_W-1:0] used;

  always_comb begin
    seen_eff  = first_word ? '0 : seen_r;
    total_eff = first_word ? '0 : total_r;
    hits      = '0;
    used      = '0;
    for (int j = 0; j < pcts_pkg::MAX_CODES; j++) begin
      // code j is live while the codes before it still leave room
      slot = {1'b0, seen_eff} + (pcts_pkg::CNT_W + 1)'(j);
      if (codes.complete[j] && (slot < {1'b0, value_count})) begin
        used = used + 1'b1;
        if (codes.code[j] > threshold) begin
          hits = hits + 1'b1;
        end
      end
    end
    seen_nxt      = seen_eff + pcts_pkg::CNT_W'(used);
    total_nxt     = total_eff + pcts_pkg::CNT_W'(hits);
    word_matches  = hits;
    total_matches = total_nxt;
    done_res      = seen_nxt >= value_count;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r  <= '0;
      total_r <= '0;
    end else if (step) begin
      seen_r  <= seen_nxt;
      total_r <= total_nxt;
    end
  end

endmodule

`default_nettype wire

### design/packed_column_threshold_scan_unit.sv
// top level: input register, code unpack, counting and result register
// an accepted word waits in the input register until the result register is free, then its result is registered there
// throughput: one word per cycle while results are taken; unpack and count are combinational
// a result waiting in the output register lets one more word into the input register, then holds further words
// reset (synchronous, active low) clears leftover bits, counters, config registers and valids
`default_nettype none

module packed_column_threshold_scan_unit (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [pcts_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [pcts_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire  [pcts_pkg::WORD_BITS-1:0]      in_packed_word,
  input  wire                                 in_first_word,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic [pcts_pkg::HIT_W-1:0]          out_word_matches,
  output logic [pcts_pkg::CNT_W-1:0]          out_total_matches,
  output logic                                out_done_res
);

  logic [pcts_pkg::CODE_BITS-1:0] threshold_r;
  logic [pcts_pkg::CNT_W-1:0]     value_count_r;

  logic                           in_vld_r;
  logic [pcts_pkg::WORD_BITS-1:0] word_r;
  logic                           first_r;

  logic                           out_vld_r;
  logic [pcts_pkg::HIT_W-1:0]     matches_r;
  logic [pcts_pkg::CNT_W-1:0]     total_r;
  logic                           done_r;

  logic                           adv;
  logic                           in_acc;
  pcts_pkg::code_bundle_t         codes;
  logic [pcts_pkg::HIT_W-1:0]     matches_nxt;
  logic [pcts_pkg::CNT_W-1:0]     total_nxt;
  logic                           done_nxt;

  assign cfg_ready = 1'b1;
  assign adv       = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || adv;
  assign in_acc    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r   <= '0;
      value_count_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pcts_pkg::CFG_THRESHOLD:   threshold_r   <= cfg_data[pcts_pkg::CODE_BITS-1:0];
        pcts_pkg::CFG_VALUE_COUNT: value_count_r <= cfg_data[pcts_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  pcts_unpack u_unpack (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (adv),
    .word       (word_r),
    .first_word (first_r),
    .codes      (codes)
  );

  pcts_count u_count (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (adv),
    .first_word    (first_r),
    .codes         (codes),
    .threshold     (threshold_r),
    .value_count   (value_count_r),
    .word_matches  (matches_nxt),
    .total_matches (total_nxt),
    .done_res      (done_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_acc || (in_vld_r && !adv);
      out_vld_r <= adv || (out_vld_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      word_r  <= in_packed_word;
      first_r <= in_first_word;
    end
    if (adv) begin
      matches_r <= matches_nxt;
      total_r   <= total_nxt;
      done_r    <= done_nxt;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_word_matches  = matches_r;
  assign out_total_matches = total_r;
  assign out_done_res      = done_r;

endmodule

`default_nettype wire

### test/packed_column_threshold_scan_unit_test.sv
// testbench for the packed column threshold scan unit: packed columns, register changes, stalls
module packed_column_threshold_scan_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WORD_GOAL = 1650;
  localparam int MAX_GAP   = 13;

  typedef struct packed {
    logic [pcts_pkg::HIT_W-1:0] word_matches;
    logic [pcts_pkg::CNT_W-1:0] total_matches;
    logic                       done;
  } tally_t;

  typedef enum {FILL_MIXED, FILL_ZEROS, FILL_ONES} fill_t;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [pcts_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [pcts_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                            in_valid;
  logic                            in_ready;
  logic [pcts_pkg::WORD_BITS-1:0]  in_packed_word;
  logic                            in_first_word;
  logic                            out_valid;
  logic                            out_ready;
  logic [pcts_pkg::HIT_W-1:0]      out_word_matches;
  logic [pcts_pkg::CNT_W-1:0]      out_total_matches;
  logic                            out_done_res;

  // scan state as the block should hold it
  logic [pcts_pkg::CARRY_BITS-1:0] left_bits  = '0;
  logic [pcts_pkg::LEN_W-1:0]      left_len   = '0;
  logic [pcts_pkg::CNT_W-1:0]      codes_done = '0;
  logic [pcts_pkg::CNT_W-1:0]      hit_total  = '0;
  pcts_pkg::code_t                 thr_reg    = '0;
  logic [pcts_pkg::CNT_W-1:0]      count_reg  = '0;

  tally_t tallies_due[$];

  bit sender_idle   = 1'b1;
  bit receiver_idle = 1'b1;
  int hold_cycles   = 0;

  int words_sent      = 0;
  int scans           = 0;
  int reg_writes      = 0;
  int results_checked = 0;
  int mismatches      = 0;

  packed_column_threshold_scan_unit i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_packed_word    (in_packed_word),
    .in_first_word     (in_first_word),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_word_matches  (out_word_matches),
    .out_total_matches (out_total_matches),
    .out_done_res      (out_done_res)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic tally_t tally_word(input logic [pcts_pkg::WORD_BITS-1:0] w,
                                        input logic first);
    pcts_pkg::code_t acc;
    int unsigned     len;
    int unsigned     hits;
    int              b;
    tally_t          t;
    if (first) begin
      left_bits  = '0;
      left_len   = '0;
      codes_done = '0;
      hit_total  = '0;
    end
    len = left_len;
    if (len >= pcts_pkg::CODE_BITS) len = 0;
    acc  = pcts_pkg::code_t'(left_bits);
    hits = 0;
    for (b = pcts_pkg::WORD_BITS - 1; b >= 0; b--) begin
      acc = {acc[pcts_pkg::CODE_BITS-2:0], w[b]};
      len++;
      if (len == pcts_pkg::CODE_BITS) begin
        // codes beyond value_count are padding and leave the counters alone
        if (codes_done < count_reg) begin
          if (acc > thr_reg) begin
            hits++;
            hit_total++;
          end
          codes_done++;
        end
        acc = '0;
        len = 0;
      end
    end
    left_bits         = acc[pcts_pkg::CARRY_BITS-1:0];
    left_len          = pcts_pkg::LEN_W'(len);
    t.word_matches    = pcts_pkg::HIT_W'(hits);
    t.total_matches   = hit_total;
    t.done            = (codes_done >= count_reg);
    return t;
  endfunction

  function automatic int pick_gap(input bit on);
    return on ? int'($urandom_range(0, MAX_GAP)) : 0;
  endfunction

  function automatic logic [pcts_pkg::WORD_BITS-1:0] fill_word(input fill_t style);
    case (style)
      FILL_ZEROS: return '0;
      FILL_ONES:  return '1;
      default:    return {$urandom, $urandom};
    endcase
  endfunction

  // random codes cluster around the threshold so both sides of the compare get hit
  function automatic pcts_pkg::code_t pick_code(input fill_t style);
    pcts_pkg::code_t c;
    case (style)
      FILL_ZEROS: c = '0;
      FILL_ONES:  c = '1;
      default: begin
        case ($urandom_range(0, 6))
          0:       c = thr_reg;
          1:       c = thr_reg + 1'b1;
          2:       c = thr_reg - 1'b1;
          3:       c = '0;
          4:       c = '1;
          default: c = pcts_pkg::code_t'($urandom);
        endcase
      end
    endcase
    return c;
  endfunction

  task automatic report_mismatch(input string what, input tally_t want);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected hits %0d total %0d done %0b, got hits %0d total %0d done %0b",
               $time, what, want.word_matches, want.total_matches, want.done,
               out_word_matches, out_total_matches, out_done_res);
  endtask

  task automatic offer_word(input logic [pcts_pkg::WORD_BITS-1:0] w, input logic first);
    int gap;
    gap = pick_gap(sender_idle);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_packed_word <= w;
    in_first_word  <= first;
    do @(posedge clk); while (in_ready !== 1'b1);
    tallies_due.push_back(tally_word(w, first));
    words_sent++;
  endtask

  task automatic drain_block();
    in_valid <= 1'b0;
    while (tallies_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [pcts_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pcts_pkg::CFG_DATA_W-1:0] data,
                           input bit more);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (!more) cfg_valid <= 1'b0;
    case (idx)
      pcts_pkg::CFG_THRESHOLD:   thr_reg = data[pcts_pkg::CODE_BITS-1:0];
      pcts_pkg::CFG_VALUE_COUNT: count_reg = data[pcts_pkg::CNT_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic load_config(input pcts_pkg::code_t thr, input logic [pcts_pkg::CNT_W-1:0] cnt);
    write_reg(pcts_pkg::CFG_THRESHOLD, pcts_pkg::CFG_DATA_W'(thr), 1'b1);
    write_reg(pcts_pkg::CFG_VALUE_COUNT, cnt, 1'b0);
  endtask

  task automatic scan_column(input int n_codes, input int pad_words, input fill_t style);
    logic [pcts_pkg::WORD_BITS-1:0] w;
    pcts_pkg::code_t                c;
    int                             used;
    int                             i;
    int                             k;
    logic                           first;
    w     = fill_word(style);
    used  = 0;
    first = 1'b1;
    scans++;
    for (i = 0; i < n_codes; i++) begin
      c = pick_code(style);
      for (k = pcts_pkg::CODE_BITS - 1; k >= 0; k--) begin
        w[pcts_pkg::WORD_BITS-1-used] = c[k];
        used++;
        if (used == pcts_pkg::WORD_BITS) begin
          offer_word(w, first);
          first = 1'b0;
          w     = fill_word(style);
          used  = 0;
        end
      end
    end
    // partial last word, or an empty column that still needs its first word
    if (used != 0 || first) offer_word(w, first);
    repeat (pad_words) offer_word(fill_word(style), 1'b0);
  endtask

  task automatic send_noise(input int n_words);
    repeat (n_words) offer_word(fill_word(FILL_MIXED), $urandom_range(0, 3) == 0);
  endtask

  task automatic test_after_reset();
    // registers still at reset: nothing counts and done shows from the first word
    offer_word('1, 1'b0);
    offer_word('0, 1'b0);
    drain_block();
  endtask

  task automatic test_threshold_extremes();
    load_config('0, 24'd8);
    scan_column(8, 0, FILL_ONES);
    drain_block();
    load_config('1, 24'd8);
    scan_column(8, 0, FILL_ONES);
    drain_block();
    load_config('0, 24'd8);
    scan_column(8, 0, FILL_ZEROS);
    drain_block();
  endtask

  task automatic test_padding_and_zero_count();
    load_config(pcts_pkg::code_t'(100), 24'd5);
    scan_column(9, 1, FILL_MIXED);
    drain_block();
    load_config('0, '0);
    scan_column(4, 0, FILL_ONES);
    drain_block();
  endtask

  task automatic test_register_changes();
    load_config(pcts_pkg::code_t'(17'h10000), 24'd12);
    scan_column(6, 0, FILL_MIXED);
    drain_block();
    // new threshold applies from the code still split across words
    write_reg(pcts_pkg::CFG_THRESHOLD, '0, 1'b0);
    offer_word(fill_word(FILL_MIXED), 1'b0);
    offer_word(fill_word(FILL_MIXED), 1'b0);
    drain_block();
    // value_count below the codes already seen: counters freeze
    write_reg(pcts_pkg::CFG_VALUE_COUNT, 24'd2, 1'b0);
    offer_word(fill_word(FILL_ONES), 1'b0);
    drain_block();
    write_reg(pcts_pkg::CFG_VALUE_COUNT, '1, 1'b0);
    offer_word(fill_word(FILL_ONES), 1'b0);
    offer_word(fill_word(FILL_ONES), 1'b1);
    drain_block();
  endtask

  task automatic test_random_scans();
    int                         n;
    pcts_pkg::code_t            thr;
    logic [pcts_pkg::CNT_W-1:0] cnt;
    while (words_sent < WORD_GOAL) begin
      sender_idle   = ($urandom_range(0, 3) != 0);
      receiver_idle = ($urandom_range(0, 3) != 0);
      n = ($urandom_range(0, 19) == 0) ? int'($urandom_range(150, 300))
                                       : int'($urandom_range(0, 40));
      case ($urandom_range(0, 3))
        0:       thr = '0;
        1:       thr = '1;
        default: thr = pcts_pkg::code_t'($urandom);
      endcase
      case ($urandom_range(0, 5))
        0:       cnt = pcts_pkg::CNT_W'(n);
        1:       cnt = (n > 3) ? pcts_pkg::CNT_W'(n - int'($urandom_range(1, 3))) : '0;
        2:       cnt = pcts_pkg::CNT_W'(n + int'($urandom_range(1, 5)));
        3:       cnt = '0;
        4:       cnt = '1;
        default: cnt = pcts_pkg::CNT_W'($urandom_range(0, n));
      endcase
      drain_block();
      load_config(thr, cnt);
      scan_column(n, $urandom_range(0, 3), FILL_MIXED);
      if ($urandom_range(0, 5) == 0) send_noise($urandom_range(1, 4));
      if ($urandom_range(0, 7) == 0) begin
        drain_block();
        if ($urandom_range(0, 1) == 0)
          write_reg(pcts_pkg::CFG_THRESHOLD,
                    pcts_pkg::CFG_DATA_W'(pcts_pkg::code_t'($urandom)), 1'b0);
        else
          write_reg(pcts_pkg::CFG_VALUE_COUNT,
                    pcts_pkg::CFG_DATA_W'($urandom_range(0, n + 4)), 1'b0);
        send_noise($urandom_range(1, 3));
      end
    end
    drain_block();
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
  endtask

  task automatic test_output_stall();
    sender_idle   = 1'b0;
    receiver_idle = 1'b0;
    load_config(pcts_pkg::code_t'($urandom), 24'd200);
    hold_cycles = 120;
    scan_column(120, 0, FILL_MIXED);
    drain_block();
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
  endtask

  initial begin : result_sink
    int stall;
    forever begin
      if (hold_cycles > 0) begin
        stall       = hold_cycles;
        hold_cycles = 0;
      end else begin
        stall = pick_gap(receiver_idle);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  always @(posedge clk) begin : tally_check
    tally_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      results_checked++;
      if (tallies_due.size() == 0) begin
        want = '0;
        report_mismatch("item result with nothing pending", want);
      end else begin
        want = tallies_due.pop_front();
        if (out_word_matches !== want.word_matches ||
            out_total_matches !== want.total_matches ||
            out_done_res !== want.done)
          report_mismatch("item result wrong", want);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results still pending", tallies_due.size());
    $display("FAIL packed_column_threshold_scan_unit");
    $finish;
  end

  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_packed_word <= '0;
    in_first_word  <= 1'b0;
    cfg_valid      <= 1'b0;
    cfg_index      <= pcts_pkg::CFG_THRESHOLD;
    cfg_data       <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_after_reset();
    test_threshold_extremes();
    test_padding_and_zero_count();
    test_register_changes();
    test_random_scans();
    test_output_stall();
    drain_block();
    $display("scanned %0d words in %0d columns, %0d register writes, %0d results compared",
             words_sent, scans, reg_writes, results_checked);
    $display("threshold and value_count extremes, padding, mid-scan writes, long stall: %0d %s",
             mismatches, "mismatches");
    if (mismatches == 0) begin
      $display("PASS packed_column_threshold_scan_unit");
    end else begin
      $display("FAIL packed_column_threshold_scan_unit");
    end
    $finish;
  end

endmodule

### packed_column_threshold_scan_unit.f
design/pcts_pkg.sv
design/pcts_unpack.sv
design/pcts_count.sv
design/packed_column_threshold_scan_unit.sv
test/packed_column_threshold_scan_unit_test.sv
